>>> rtl/assert_macros.svh
// assertion macros for the rtl files that carry checks
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dshot gcr encoder check failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("dshot gcr encoder forbidden condition");

`endif

>>> rtl/dsgcr_pkg.sv
// types, constants and coding functions of the dshot telemetry gcr encoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dsgcr_pkg;

  localparam int unsigned CodeWidth        = 20;
  localparam int unsigned SlotWidth        = 5;
  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [SlotWidth-1:0] LastSlot      = 5'd21;
  localparam logic [SlotWidth-1:0] StartSlot     = 5'd1;
  localparam logic [SlotWidth-1:0] LeadSlot      = 5'd0;
  localparam logic [7:0]           HighCmpReset  = 8'd128;
  localparam logic [15:0]          StoppedPeriod = 16'hffff;
  localparam logic [3:0]           NibbleMask    = 4'hf;

  typedef logic [CodeWidth-1:0] code_t;

  typedef struct packed {
    logic [15:0] period;
    logic        motor_running;
    logic        extended_pending;
    logic [11:0] extended_word;
  } req_t;

  typedef struct packed {
    logic       line_level;
    logic [7:0] compare_value;
    logic       last_slot;
  } rsp_t;

  typedef struct packed {
    logic                 active;
    logic [SlotWidth-1:0] slot;
  } back_status_t;

  function automatic logic [4:0] gcr_nibble(input logic [3:0] n);
    logic [4:0] g;
    case (n)
      4'h0:    g = 5'h19;
      4'h1:    g = 5'h1b;
      4'h2:    g = 5'h12;
      4'h3:    g = 5'h13;
      4'h4:    g = 5'h1d;
      4'h5:    g = 5'h15;
      4'h6:    g = 5'h16;
      4'h7:    g = 5'h17;
      4'h8:    g = 5'h1a;
      4'h9:    g = 5'h09;
      4'ha:    g = 5'h0a;
      4'hb:    g = 5'h0b;
      4'hc:    g = 5'h1e;
      4'hd:    g = 5'h0d;
      4'he:    g = 5'h0e;
      4'hf:    g = 5'h0f;
      default: g = 5'h0f;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/dsgcr_front.sv
// front end: accepts a telemetry request, forms the 12-bit payload and gcr code
// depends on dsgcr_pkg
`timescale 1ns / 1ps

module dsgcr_front
  import dsgcr_pkg::*;
(
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  req_t  in_req_i,
  output logic  push_valid_o,
  input  logic  push_ready_i,
  output code_t push_code_o
);

  logic [15:0] period;
  logic [2:0]  expo;
  logic [8:0]  mant;
  logic [11:0] payload;
  logic [3:0]  chk;
  logic [15:0] word16;

  always_comb begin
    period = in_req_i.motor_running ? in_req_i.period : StoppedPeriod;
    // exponent follows the leading one among bits 15..9
    expo = 3'd0;
    for (int b = 9; b < 16; b++) begin
      if (period[b]) begin
        expo = 3'(b - 8);
      end
    end
    mant = 9'(period >> expo);
    payload = in_req_i.extended_pending ? in_req_i.extended_word : {expo, mant};
    chk = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]) & NibbleMask;
    word16 = {payload, chk};
  end

  assign push_code_o = {gcr_nibble(word16[15:12]), gcr_nibble(word16[11:8]),
                        gcr_nibble(word16[7:4]), gcr_nibble(word16[3:0])};

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

>>> rtl/dsgcr_fifo.sv
// short code word queue between front and back ends
// depends on dsgcr_pkg
`timescale 1ns / 1ps

module dsgcr_fifo
  import dsgcr_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  code_t push_code_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output code_t pop_code_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  code_t               mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_code_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_code_i;
    end
  end

endmodule

>>> rtl/dsgcr_back.sv
// back end: nrzi serializer producing 22 line slots per code word
// depends on dsgcr_pkg
`timescale 1ns / 1ps

module dsgcr_back
  import dsgcr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   high_compare_i,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  code_t        pop_code_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output rsp_t         out_rsp_o,
  output back_status_t status_o
);

  logic                 active_q, active_d;
  logic [SlotWidth-1:0] slot_q, slot_d;
  logic                 lvl_q, lvl_d;
  code_t                code_q, code_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 out_free, emit, is_last, pop, level;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    emit     = active_q && out_free;
    is_last  = (slot_q == LastSlot);
    pop      = pop_valid_i && (!active_q || (emit && is_last));

    // low lead slot, high start slot, then one nrzi slot per code bit, toggling on a one
    if (slot_q == LeadSlot) begin
      level = 1'b0;
    end else if (slot_q == StartSlot) begin
      level = 1'b1;
    end else begin
      level = lvl_q ^ code_q[CodeWidth-1];
    end

    active_d    = active_q;
    slot_d      = slot_q;
    lvl_d       = lvl_q;
    code_d      = code_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rsp_d       = rsp_q;

    if (emit) begin
      out_valid_d         = 1'b1;
      rsp_d.line_level    = level;
      rsp_d.compare_value = level ? high_compare_i : 8'd0;
      rsp_d.last_slot     = is_last;
      lvl_d               = level;
      slot_d              = slot_q + 1'b1;
      if (slot_q > StartSlot) begin
        code_d = code_q << 1;
      end
      if (is_last) begin
        active_d = 1'b0;
      end
    end
    if (pop) begin
      active_d = 1'b1;
      slot_d   = LeadSlot;
      code_d   = pop_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      slot_q      <= '0;
      lvl_q       <= 1'b1;
      code_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      slot_q      <= slot_d;
      lvl_q       <= lvl_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign pop_ready_o     = !active_q || (emit && is_last);
  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = rsp_q;
  assign status_o.active = active_q;
  assign status_o.slot   = slot_q;

endmodule

>>> rtl/dshot_telemetry_gcr_encoder.sv
// first slot of a request passes the code queue, serializer state and output register
// throughput: one line slot per cycle from the serializer unless out_ready_i stalls it
// a code queue of FifoDepth entries lets requests be taken while a frame is shifting out
// reset (async, active low) empties the queue and output, high_compare returns to 128
// depends on dsgcr_pkg, dsgcr_front, dsgcr_fifo, dsgcr_back, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dshot_telemetry_gcr_encoder
  import dsgcr_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_rsp_o
);

  logic [7:0]   high_compare_q;
  logic         push_valid, push_ready, pop_valid, pop_ready;
  code_t        push_code, pop_code;
  back_status_t back_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_compare_q <= HighCmpReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      high_compare_q <= cfg_data_i;
    end
  end

  dsgcr_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_code_o (push_code)
  );

  dsgcr_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_code_i (push_code),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_code_o  (pop_code)
  );

  dsgcr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .high_compare_i(high_compare_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_code_i    (pop_code),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_rsp_o     (out_rsp_o),
    .status_o      (back_status)
  );

  // an accepted request is queued or already being serialized in the next cycle
  `ASSERT_CLK(a_req_tracked, clk_i, rst_ni,
              (in_valid_i && in_ready_o) |=> (pop_valid || back_status.active))
  // the slot after the final one always opens a new frame with a low level
  `ASSERT_CLK(a_frame_restarts_low, clk_i, rst_ni,
              (out_valid_o && out_ready_i && out_rsp_o.last_slot)
                |=> (!out_valid_o || !out_rsp_o.line_level))
  // the serializer never loads a new word while mid frame
  `ASSERT_NEVER(a_no_midframe_pop, clk_i, rst_ni,
                pop_valid && pop_ready && back_status.active
                  && (back_status.slot != LastSlot))

endmodule

>>> test/tb_dshot_telemetry_gcr_encoder.sv
// self-checking testbench for dshot_telemetry_gcr_encoder: random and directed telemetry
// requests, a frame predictor with a slot queue, random request gaps and output stalls
// depends on dsgcr_pkg and the encoder rtl
`timescale 1ns / 1ps

module tb_dshot_telemetry_gcr_encoder
  import dsgcr_pkg::*;
();

  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned TailCycles = 30;
  localparam int unsigned FrameLen   = 22;

  // 4b/5b code per nibble, nibble 15 in the top five bits
  localparam logic [79:0] GcrMap = {
    5'h0f, 5'h0e, 5'h0d, 5'h1e, 5'h0b, 5'h0a, 5'h09, 5'h1a,
    5'h17, 5'h16, 5'h15, 5'h1d, 5'h13, 5'h12, 5'h1b, 5'h19
  };

  class gcr_frame_board;
    logic [7:0]  high_cmp;
    logic [19:0] last_code;
    logic        last_level;
    rsp_t        expected_slots[$];
    int          errors;

    function new();
      high_cmp   = 8'd128;
      last_code  = '0;
      last_level = 1'b1;
      errors     = 0;
    endfunction

    // builds the 22 slots that one accepted request must produce
    function void note_request(req_t r);
      logic [15:0] p;
      logic [3:0]  e;
      logic [11:0] payload;
      logic [15:0] word;
      rsp_t        s;
      if (r.extended_pending) begin
        payload = r.extended_word;
      end else begin
        p = r.motor_running ? r.period : 16'hffff;
        e = '0;
        for (int b = 9; b <= 15; b++) begin
          if (p[b]) begin
            e = 4'(b - 8);
          end
        end
        payload = {e[2:0], 9'(p >> e)};
      end
      word = {payload, ~(payload[11:8] ^ payload[7:4] ^ payload[3:0])};
      last_code = {GcrMap[word[15:12]*5 +: 5], GcrMap[word[11:8]*5 +: 5],
                   GcrMap[word[7:4]*5 +: 5], GcrMap[word[3:0]*5 +: 5]};
      for (int k = 0; k < FrameLen; k++) begin
        if (k == 0) begin
          last_level = 1'b0;
        end else if (k == 1) begin
          last_level = 1'b1;
        end else begin
          last_level = last_level ^ last_code[21-k];
        end
        s.line_level    = last_level;
        s.compare_value = last_level ? high_cmp : 8'd0;
        s.last_slot     = (k == FrameLen - 1);
        expected_slots.push_back(s);
      end
    endfunction

    function void check_slot(rsp_t got);
      rsp_t want;
      if (expected_slots.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected slot: level %0b cmp %0d last %0b",
                   got.line_level, got.compare_value, got.last_slot);
        end
        return;
      end
      want = expected_slots.pop_front();
      if (got.line_level !== want.line_level || got.compare_value !== want.compare_value ||
          got.last_slot !== want.last_slot) begin
        errors++;
        if (errors <= 10) begin
          $display("slot mismatch: level exp %0b got %0b, cmp exp %0d got %0d, last exp %0b got %0b",
                   want.line_level, got.line_level, want.compare_value, got.compare_value,
                   want.last_slot, got.last_slot);
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  req_t       in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  rsp_t       out_rsp_o;

  gcr_frame_board board;
  int unsigned    gap_pct;
  int unsigned    stall_pct;
  int unsigned    stuck_cycles = 0;

  always #6 clk_i = ~clk_i;

  dshot_telemetry_gcr_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // watches every channel: predicts, checks, and catches a hung block
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        board.high_cmp = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        board.note_request(in_req_i);
      end
      if (out_valid_o && out_ready_i) begin
        board.check_slot(out_rsp_o);
      end
    end
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("[dshot_telemetry_gcr_encoder] ERROR");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(req_t r);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_slots.size() != 0);
  endtask

  task automatic set_high_compare(logic [7:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t make_request(logic [15:0] period, logic running, logic pending,
                                        logic [11:0] word);
    req_t r;
    r.period           = period;
    r.motor_running    = running;
    r.extended_pending = pending;
    r.extended_word    = word;
    return r;
  endfunction

  // period shifted by a random amount so every exponent shows up
  function automatic req_t random_request();
    return make_request(16'($urandom_range(0, 65535) >> $urandom_range(0, 15)),
                        $urandom_range(0, 5) != 0, $urandom_range(0, 3) == 0,
                        12'($urandom_range(0, 4095)));
  endfunction

  task automatic run_phase(logic [7:0] cmp, int unsigned n, int unsigned gap,
                           int unsigned stall);
    set_high_compare(cmp);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (n) send_request(random_request());
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    in_req_i     <= '0;
    gap_pct      = 30;
    stall_pct    = 20;
    board        = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // exponent boundaries, stopped motor, extended words, at the reset compare value
    send_request(make_request(16'd0, 1'b1, 1'b0, 12'h000));
    send_request(make_request(16'd1, 1'b1, 1'b0, 12'h000));
    send_request(make_request(16'd511, 1'b1, 1'b0, 12'h000));
    send_request(make_request(16'd512, 1'b1, 1'b0, 12'h000));
    send_request(make_request(16'd1023, 1'b1, 1'b0, 12'h000));
    send_request(make_request(16'd1024, 1'b1, 1'b0, 12'h000));
    send_request(make_request(16'h7fff, 1'b1, 1'b0, 12'h000));
    send_request(make_request(16'h8000, 1'b1, 1'b0, 12'h000));
    send_request(make_request(16'hffff, 1'b1, 1'b0, 12'hfff));
    send_request(make_request(16'd1234, 1'b0, 1'b0, 12'h000));
    send_request(make_request(16'd0, 1'b0, 1'b0, 12'hfff));
    // pending word of zero still goes out as an extended frame
    send_request(make_request(16'd100, 1'b1, 1'b1, 12'h000));
    // pending beats a stopped motor
    send_request(make_request(16'hffff, 1'b0, 1'b1, 12'habc));
    send_request(make_request(16'd0, 1'b1, 1'b1, 12'hfff));
    send_request(make_request(16'h5555, 1'b1, 1'b1, 12'h555));
    send_request(make_request(16'haaaa, 1'b0, 1'b1, 12'haaa));

    run_phase(8'd1, 30, 40, 30);
    run_phase(8'd255, 30, 10, 50);
    // zero compare: high slots still report level 1
    run_phase(8'd0, 20, 25, 25);
    run_phase(8'($urandom_range(2, 254)), 40, 20, 20);
    run_phase(8'd64, 50, 0, 0);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.expected_slots.size() == 0) begin
      $display("[dshot_telemetry_gcr_encoder] OK");
    end else begin
      $display("[dshot_telemetry_gcr_encoder] ERROR");
    end
    $finish;
  end

endmodule
